/* hdl/secal_pkg.sv */
// Shared types and constants of the steering end-stop calibrator.
package secal_pkg;

  // Calibration phase, one-hot in the state register.
  typedef enum logic [3:0] {
    PH_RIGHT  = 4'b0001,
    PH_LEFT   = 4'b0010,
    PH_CENTER = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Phase codes as reported on the result channel.
  localparam logic [1:0] PHASE_CODE_RIGHT  = 2'd0;
  localparam logic [1:0] PHASE_CODE_LEFT   = 2'd1;
  localparam logic [1:0] PHASE_CODE_CENTER = 2'd2;
  localparam logic [1:0] PHASE_CODE_DONE   = 2'd3;

  // Configuration register map.
  localparam int unsigned CFG_INDEX_WIDTH = 1;
  localparam int unsigned CFG_DATA_WIDTH  = 8;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DRIVE_SPEED      = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_TOLERANCE = 1'd1;

  localparam int unsigned SPEED_WIDTH = 7;
  localparam int unsigned TOL_WIDTH   = 8;
  localparam int unsigned PWM_WIDTH   = 8;

  localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 7'd50;
  localparam logic [TOL_WIDTH-1:0]   TOL_RESET   = 8'd3;
  localparam logic [SPEED_WIDTH-1:0] PWM_MAX     = 7'd100;

  // Largest sample-to-sample change still taken as a stall.
  localparam int STALL_JITTER = 1;
  // The left stall must lie more than this distance below the right end.
  localparam int MIN_SPAN     = 10;

endpackage

/* hdl/secal_if.sv */
// Request channels of the steering end-stop calibrator.
interface secal_sample_if #(
  parameter int COUNT_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] encoder_count;

  modport source (output valid, output encoder_count, input ready);
  modport sink   (input valid, input encoder_count, output ready);
endinterface

interface secal_result_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [secal_pkg::PWM_WIDTH-1:0]     turn_pwm;
  logic                                       clear_count;
  logic                                       is_calibrated;
  logic                                       is_centered;
  logic [1:0]                                 phase;

  modport source (output valid, output turn_pwm, output clear_count, output is_calibrated,
                  output is_centered, output phase, input ready);
  modport sink   (input valid, input turn_pwm, input clear_count, input is_calibrated,
                  input is_centered, input phase, output ready);
endinterface

/* hdl/steering_end_stop_calibrator.sv */
// Steering end-stop calibrator: sweeps to both end stops, centers, then reports centering.
//
// One encoder sample request is taken per clock and its result request is
// registered on the next edge, so the block sustains one request per cycle
// while results are taken; the single result register is the only stage. A new sample
// is accepted whenever the result register is empty or is being drained in the same
// cycle. The calibration first drives right until two consecutive samples
// differ by at most one count and records the previous sample as the right
// end; it then drives left until such a stall occurs more than ten counts
// below the right end and records the left end; it then drives toward the
// midpoint (rounded toward zero) and, once the sample is within
// center_tolerance of it, pulses clear_count and reports calibrated. In the
// done phase the sample only feeds the centered test against zero; only
// reset restarts calibration. A drive speed above 100 is saturated to 100.
// Configuration writes take effect on the next edge and should be made
// while no request is in flight.
module steering_end_stop_calibrator #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_we,
  input  logic [secal_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
  input  logic [secal_pkg::CFG_DATA_WIDTH-1:0]        cfg_data,
  secal_sample_if.sink                                sample,
  secal_result_if.source                              result
);

  localparam int W = COUNT_WIDTH;

  // Configuration registers
  logic [secal_pkg::SPEED_WIDTH-1:0] drive_speed;
  logic [secal_pkg::TOL_WIDTH-1:0]   center_tolerance;

  // Calibration state
  secal_pkg::phase_t      phase_reg, phase_next;
  logic signed [W-1:0]    prev_count, prev_count_next;
  logic                   prev_valid, prev_valid_next;
  logic signed [W-1:0]    right_end, right_end_next;
  logic signed [W-1:0]    left_end, left_end_next;
  logic                   done_flag, done_flag_next;

  // Result register
  logic                                      res_valid;
  logic signed [secal_pkg::PWM_WIDTH-1:0]    turn_pwm, turn_pwm_next;
  logic                                      clear_count, clear_next;
  logic                                      is_centered, centered_next;
  logic [1:0]                                phase_code_next, phase_code;
  logic                                      is_calibrated;

  logic accept;

  // Datapath
  logic signed [W-1:0]                    count;
  logic signed [W:0]                      count_x, diff, right_lim, end_sum, round_sum, mid_x;
  logic signed [W+1:0]                    count_xx, mid_xx, tol_xx, win_lo, win_hi, neg_tol;
  logic                                   stall, span_ok, in_window, near_zero, below_mid;
  logic [secal_pkg::SPEED_WIDTH-1:0]      speed;
  logic signed [secal_pkg::PWM_WIDTH-1:0] pwm_pos, pwm_neg;

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = !res_valid || result.ready;

  assign count    = sample.encoder_count;
  assign count_x  = {count[W-1], count};
  assign count_xx = {{2{count[W-1]}}, count};

  // Stall: previous sample present and |count - prev| <= jitter.
  assign diff  = count_x - {prev_count[W-1], prev_count};
  assign stall = prev_valid && (diff >= -(W+1)'(secal_pkg::STALL_JITTER))
                            && (diff <=  (W+1)'(secal_pkg::STALL_JITTER));

  // Left stall must lie more than the minimum span below the right end.
  assign right_lim = {right_end[W-1], right_end} - (W+1)'(secal_pkg::MIN_SPAN);
  assign span_ok   = count_x < right_lim;

  // Midpoint rounded toward zero: bias odd negative sums up by one before the shift.
  assign end_sum   = {left_end[W-1], left_end} + {right_end[W-1], right_end};
  assign round_sum = end_sum + (W+1)'(end_sum[W] & end_sum[0]);
  assign mid_x     = round_sum >>> 1;
  assign mid_xx    = {mid_x[W], mid_x};

  assign tol_xx    = (W+2)'(center_tolerance);
  assign win_lo    = mid_xx - tol_xx;
  assign win_hi    = mid_xx + tol_xx;
  assign in_window = (count_xx >= win_lo) && (count_xx <= win_hi);
  assign below_mid = count_xx < mid_xx;

  assign neg_tol   = -tol_xx;
  assign near_zero = (count_xx >= neg_tol) && (count_xx <= tol_xx);

  // Saturate the drive magnitude.
  assign speed   = (drive_speed > secal_pkg::PWM_MAX) ? secal_pkg::PWM_MAX : drive_speed;
  assign pwm_pos = {1'b0, speed};
  assign pwm_neg = -pwm_pos;

  always_comb begin
    phase_next      = phase_reg;
    prev_count_next = count;
    prev_valid_next = 1'b1;
    right_end_next  = right_end;
    left_end_next   = left_end;
    done_flag_next  = done_flag;
    turn_pwm_next   = '0;
    clear_next      = 1'b0;
    centered_next   = 1'b0;
    case (phase_reg)
      secal_pkg::PH_RIGHT: begin
        turn_pwm_next = pwm_pos;
        if (stall) begin
          // Record the previous sample as the right end and reverse.
          right_end_next = prev_count;
          phase_next     = secal_pkg::PH_LEFT;
          turn_pwm_next  = pwm_neg;
        end
      end
      secal_pkg::PH_LEFT: begin
        turn_pwm_next = pwm_neg;
        if (stall && span_ok) begin
          left_end_next = prev_count;
          phase_next    = secal_pkg::PH_CENTER;
          turn_pwm_next = '0;
        end
      end
      secal_pkg::PH_CENTER: begin
        if (in_window) begin
          // Centered: strobe the count clear and finish.
          phase_next     = secal_pkg::PH_DONE;
          done_flag_next = 1'b1;
          clear_next     = 1'b1;
          centered_next  = 1'b1;
        end else begin
          turn_pwm_next = below_mid ? pwm_pos : pwm_neg;
        end
      end
      secal_pkg::PH_DONE: begin
        // Hold the last sample; only report centering.
        prev_count_next = prev_count;
        prev_valid_next = prev_valid;
        centered_next   = done_flag && near_zero;
      end
      default: begin
        phase_next = secal_pkg::PH_RIGHT;
      end
    endcase
  end

  always_comb begin
    case (phase_next)
      secal_pkg::PH_RIGHT:  phase_code_next = secal_pkg::PHASE_CODE_RIGHT;
      secal_pkg::PH_LEFT:   phase_code_next = secal_pkg::PHASE_CODE_LEFT;
      secal_pkg::PH_CENTER: phase_code_next = secal_pkg::PHASE_CODE_CENTER;
      secal_pkg::PH_DONE:   phase_code_next = secal_pkg::PHASE_CODE_DONE;
      default:              phase_code_next = secal_pkg::PHASE_CODE_RIGHT;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_speed      <= secal_pkg::SPEED_RESET;
      center_tolerance <= secal_pkg::TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        secal_pkg::CFG_DRIVE_SPEED:
          drive_speed <= cfg_data[secal_pkg::SPEED_WIDTH-1:0];
        secal_pkg::CFG_CENTER_TOLERANCE:
          center_tolerance <= cfg_data[secal_pkg::TOL_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Calibration state: advance on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg  <= secal_pkg::PH_RIGHT;
      prev_count <= '0;
      prev_valid <= 1'b0;
      right_end  <= '0;
      left_end   <= '0;
      done_flag  <= 1'b0;
    end else if (accept) begin
      phase_reg  <= phase_next;
      prev_count <= prev_count_next;
      prev_valid <= prev_valid_next;
      right_end  <= right_end_next;
      left_end   <= left_end_next;
      done_flag  <= done_flag_next;
    end
  end

  // Result register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      turn_pwm      <= turn_pwm_next;
      clear_count   <= clear_next;
      is_calibrated <= done_flag_next;
      is_centered   <= centered_next;
      phase_code    <= phase_code_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.turn_pwm      = turn_pwm;
  assign result.clear_count   = clear_count;
  assign result.is_calibrated = is_calibrated;
  assign result.is_centered   = is_centered;
  assign result.phase         = phase_code;

endmodule
